/* hdl/scm_pkg.sv */
// ----------------------------------------------------------------------------
// scm_pkg
// Types, constants and state codes shared by the sigma-clipped mean unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

   localparam int MAX_SAMPLES_DEF = 64;
   localparam int SAMPLE_W        = 15;
   localparam int KEPT_W          = 7;
   localparam int CLIP_W          = 4;
   localparam logic [CLIP_W-1:0] CLIP_RESET = 4'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic [KEPT_W-1:0]   kept_count;
      logic                error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_PASS1,
      ST_KQ,
      ST_PASS2,
      ST_DIV_INIT,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;       // store an accepted item
      logic start;      // clear the square sum, latch k squared
      logic scan_init;  // rewind the read index
      logic scan;       // issue reads while entries remain
      logic pass2;      // pipeline tail classifies samples
      logic kq;         // form k squared times the square sum
      logic div_init;
      logic div_step;
      logic out_load;
      logic out_err;
      logic clear_set;
   } cmd_type;

   typedef struct packed {
      logic n_lt2;
      logic idx_done;
      logic pipe_busy;
      logic kept_zero;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

/* hdl/scm_ctrl.sv */
// ----------------------------------------------------------------------------
// scm_ctrl
// Sequencer: load, square-sum pass, clipping pass, division, result.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_ctrl
   import scm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_data.last) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.n_lt2) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.start     = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = ST_PASS1;
            end
         end
         ST_PASS1: begin
            cmd.scan = 1'b1;
            if (sts.idx_done && !sts.pipe_busy) state_in = ST_KQ;
         end
         ST_KQ: begin
            cmd.kq        = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = ST_PASS2;
         end
         ST_PASS2: begin
            cmd.scan  = 1'b1;
            cmd.pass2 = 1'b1;
            if (sts.idx_done && !sts.pipe_busy) state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            if (sts.kept_zero) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.clear_set = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/scm_datapath.sv */
// ----------------------------------------------------------------------------
// scm_datapath
// Sample store, running sums, five-stage scan pipeline and serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_datapath
   import scm_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire req_type           req_data,
   input  wire logic              csr_valid,
   input  wire logic [CLIP_W-1:0] csr_data,
   output rsp_type                rsp_data
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int SW   = SAMPLE_W + CW;
   localparam int DW   = SAMPLE_W + CW;
   localparam int D2W  = 2 * DW;
   localparam int QW   = D2W + CW;
   localparam int LW   = D2W + CW;
   localparam int KQW  = QW + 2 * CLIP_W;
   localparam int DCW  = $clog2(SW);

   logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

   logic [CLIP_W-1:0]   clip_ff;
   logic [CW-1:0]       count_ff;
   logic [SW-1:0]       sum_ff;
   logic [CW-1:0]       idx_ff;
   logic [3:0]          v_ff;
   logic [SAMPLE_W-1:0] rd_ff, x2_ff, x3_ff, x4_ff;
   logic [DW-1:0]       d_ff, d_in, nx;
   logic [D2W-1:0]      d2_ff;
   logic [LW-1:0]       lhs_ff;
   logic [QW-1:0]       q_ff;
   logic [2*CLIP_W-1:0] k2_ff;
   logic [KQW-1:0]      kq_ff;
   logic [CW-1:0]       kept_ff;
   logic [SW-1:0]       ksum_ff;
   logic [CW-1:0]       rem_ff;
   logic [SW-1:0]       quo_ff;
   logic [DCW-1:0]      dcnt_ff;
   rsp_type             out_ff;
   logic                issue;
   logic [CW-1:0]       nm1;
   logic [CW:0]         trial;
   logic                fits;

   assign issue = cmd.scan && (idx_ff != count_ff);
   assign nm1   = count_ff - CW'(1);
   assign nx    = DW'(count_ff) * DW'(rd_ff);
   assign d_in  = (nx >= DW'(sum_ff)) ? (nx - DW'(sum_ff)) : (DW'(sum_ff) - nx);
   assign trial = {rem_ff, quo_ff[SW-1]};
   assign fits  = trial >= {1'b0, kept_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= CLIP_RESET;
      end else if (csr_valid) begin
         clip_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CW'(MAX_SAMPLES))) begin
         mem[count_ff[AW-1:0]] <= req_data.sample;
      end
      if (issue) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_set) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.load && (count_ff < CW'(MAX_SAMPLES))) begin
         count_ff <= count_ff + CW'(1);
         sum_ff   <= sum_ff + SW'(req_data.sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         idx_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], issue};
         if (cmd.scan_init) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      x2_ff  <= rd_ff;
      d2_ff  <= d_ff * d_ff;
      x3_ff  <= x2_ff;
      lhs_ff <= LW'(nm1) * LW'(d2_ff);
      x4_ff  <= x3_ff;
      if (cmd.start) begin
         q_ff  <= '0;
         k2_ff <= (2*CLIP_W)'(clip_ff) * (2*CLIP_W)'(clip_ff);
      end else if (v_ff[2] && !cmd.pass2) begin
         q_ff <= q_ff + QW'(d2_ff);
      end
      if (cmd.kq) begin
         kq_ff   <= KQW'(k2_ff) * KQW'(q_ff);
         kept_ff <= '0;
         ksum_ff <= '0;
      end else if (v_ff[3] && cmd.pass2 && !(KQW'(lhs_ff) > kq_ff)) begin
         kept_ff <= kept_ff + CW'(1);
         ksum_ff <= ksum_ff + SW'(x4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= '0;
         quo_ff  <= ksum_ff;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? CW'(trial - {1'b0, kept_ff}) : CW'(trial);
         quo_ff  <= {quo_ff[SW-2:0], fits};
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
      if (cmd.out_load) begin
         if (cmd.out_err) begin
            out_ff.mean       <= '0;
            out_ff.kept_count <= '0;
            out_ff.error      <= 1'b1;
         end else begin
            out_ff.mean       <= SAMPLE_W'(quo_ff);
            out_ff.kept_count <= KEPT_W'(kept_ff);
            out_ff.error      <= 1'b0;
         end
      end
   end

   assign sts.n_lt2     = count_ff < CW'(2);
   assign sts.idx_done  = idx_ff == count_ff;
   assign sts.pipe_busy = |v_ff;
   assign sts.kept_zero = kept_ff == '0;
   assign sts.div_done  = dcnt_ff == DCW'(SW - 1);
   assign rsp_data      = out_ff;

endmodule

`default_nettype wire

/* hdl/sigma_clipped_mean_unit.sv */
// ----------------------------------------------------------------------------
// sigma_clipped_mean_unit
// Mean of a sample set after dropping samples beyond clip_factor deviations.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      sample, last
//   rsp_     out        valid / stall      mean, kept_count, error
//   csr_     in         valid / ready      clip_factor
//
// A sample that does not close the set is accepted without a stall. After a
// closing item with n stored samples the unit runs two scans of n reads, each
// followed by a pipeline drain, then a one-bit-per-cycle divider of SAMPLE_W +
// clog2(MAX_SAMPLES+1) steps and its control states; a set of fewer than two
// samples goes straight to an error result.
// Input stalls from the closing item until the result is taken.
// Reset is synchronous; clip_factor returns to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_clipped_mean_unit
   import scm_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CLIP_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   scm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   scm_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the sigma-clipped mean unit against a behavioral predictor. Sample
// sets are loaded through the request channel with random gaps and result
// stalls; each closing item yields one predicted mean, kept count and error
// flag. The clip factor is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import scm_pkg::*;

   localparam int NSTORE = 64;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CLIP_W-1:0] csr_data = '0;

   sigma_clipped_mean_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_items[$];
   rsp_type expected_means[$];
   logic [SAMPLE_W-1:0] set_samples[$];
   logic [CLIP_W-1:0] clip_k = CLIP_RESET;
   int errors = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int hold_off = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_request = 0;
   bit stim_done = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // compute the clipped mean for the closed set
   function automatic rsp_type clipped_mean(input logic [CLIP_W-1:0] k);
      rsp_type r;
      longint unsigned n, s, q, d, kept, ksum;
      logic [127:0] lhs, rhs;
      r = '0;
      r.error = 1'b1;
      n = set_samples.size();
      s = 0;
      foreach (set_samples[i]) s += set_samples[i];
      if (n >= 2) begin
         q = 0;
         foreach (set_samples[i]) begin
            d = (n * set_samples[i] >= s) ? n * set_samples[i] - s : s - n * set_samples[i];
            q += d * d;
         end
         kept = 0;
         ksum = 0;
         foreach (set_samples[i]) begin
            d = (n * set_samples[i] >= s) ? n * set_samples[i] - s : s - n * set_samples[i];
            lhs = 128'(n - 1) * 128'(d * d);
            rhs = 128'(k) * 128'(k) * 128'(q);
            if (lhs <= rhs) begin
               kept++;
               ksum += set_samples[i];
            end
         end
         if (kept != 0) begin
            r.mean = SAMPLE_W'(ksum / kept);
            r.kept_count = KEPT_W'(kept);
            r.error = 1'b0;
         end
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         if (pending_items.size() > 0 && send_gap == 0 && hold_request == 0) begin
            req_data <= pending_items[0];
            pending_items.delete(0);
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (pending_items.size() > 0 && hold_request == 0) begin
            req_valid <= 1'b1;
            req_data <= pending_items[0];
            pending_items.delete(0);
            send_gap <= pick_gap();
         end
      end
   end

   // predictor on accepted items
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (set_samples.size() < NSTORE) set_samples = {set_samples, req_data.sample};
         if (req_data.last) begin
            expected_means = {expected_means, clipped_mean(clip_k)};
            set_samples.delete();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_means.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            want = expected_means[0];
            expected_means.delete(0);
            if (rsp_data.mean !== want.mean)
               $display("%0t: mean expected %0d actual %0d", $time, want.mean, rsp_data.mean);
            if (rsp_data.kept_count !== want.kept_count)
               $display("%0t: kept_count expected %0d actual %0d", $time,
                        want.kept_count, rsp_data.kept_count);
            if (rsp_data.error !== want.error)
               $display("%0t: error expected %0d actual %0d", $time, want.error, rsp_data.error);
            if (rsp_data !== want) errors++;
         end
      end
   end

   // result stalls
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_off <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         r = $urandom_range(0, 99);
         rsp_stall <= (r < 25) || (r < 28 && rsp_stall);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || (pending_items.size() == 0 &&
          expected_means.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_means.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_clip(input logic [CLIP_W-1:0] k);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= k;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      clip_k = k;
   endtask

   task automatic add_set(input int n, input int mode);
      req_type it;
      int base;
      base = $urandom_range(0, 25600);
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: it.sample = SAMPLE_W'($urandom_range(0, 32767));
            1: it.sample = SAMPLE_W'(base + $urandom_range(0, 300) > 32767 ? base
                                     : base + $urandom_range(0, 300));
            default: it.sample = ($urandom_range(0, 9) == 0) ?
                        SAMPLE_W'($urandom_range(0, 32767)) : SAMPLE_W'(base);
         endcase
         it.last = (i == n - 1);
         pending_items = {pending_items, it};
      end
   endtask

   task automatic push_one(input int v, input bit l);
      req_type it;
      it.sample = SAMPLE_W'(v);
      it.last = l;
      pending_items = {pending_items, it};
   endtask

   task automatic random_phase(input int sets);
      int n;
      for (int s = 0; s < sets; s++) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
         add_set(n, $urandom_range(0, 2));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // single sample, pair, extremes, one outlier
      push_one(0, 1);
      push_one(32767, 0); push_one(0, 1);
      push_one(25600, 0); push_one(25600, 1);
      for (int i = 0; i < 9; i++) push_one(100, 0);
      push_one(32767, 1);
      push_one(0, 0); push_one(0, 0); push_one(25600, 1);
      wait_drained();
      // overflow: the last item lands past a full store
      add_set(NSTORE + 3, 0);
      write_clip(4'd0);
      push_one(5, 0); push_one(9, 0); push_one(7, 1);
      push_one(4, 0); push_one(4, 1);
      random_phase(9);
      write_clip(4'd1);
      random_phase(18);
      write_clip(4'd15);
      random_phase(14);
      write_clip(4'd2);
      // long receiver hold-off while items keep coming
      hold_trigger = hold_trigger + 1;
      random_phase(18);
      wait_drained();
      // sender pause after everything is back
      hold_request = 1;
      repeat (50) @(posedge clock);
      hold_request = 0;
      write_clip(CLIP_RESET);
      random_phase(27);
      write_clip(4'd7);
      random_phase(14);
      wait_drained();
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule

`default_nettype wire
